/* rtl/gdc_pkg.sv */
package gdc_pkg;

    localparam int SAMPLE_BITS     = 10;
    localparam int THR_BITS        = 16;
    localparam int THR_REG_BITS    = 4 * THR_BITS;
    localparam int DIR_BITS        = 3;
    localparam int PADDR_BITS      = 5;
    localparam int AVG_DIVISOR_DEF = 16;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_outer_right;
        logic [SAMPLE_BITS-1:0] sample_outer_left;
        logic [SAMPLE_BITS-1:0] sample_inner_left;
    } in_word_t;

    typedef struct packed {
        logic [DIR_BITS-1:0]    gaze_direction;
        logic                   direction_changed;
        logic [SAMPLE_BITS-1:0] avg_outer_right;
        logic [SAMPLE_BITS-1:0] avg_outer_left;
        logic [SAMPLE_BITS-1:0] avg_inner_left;
    } out_word_t;

    // compare flags of one detector average against its four thresholds
    typedef struct packed {
        logic ge_lo;
        logic le_lo;
        logic ge_mid_lo;
        logic le_mid_lo;
        logic ge_mid_hi;
        logic le_mid_hi;
        logic ge_hi;
        logic le_hi;
    } cmp_t;

    typedef struct packed {
        logic advance;
        logic s1_valid;
    } stage_ctl_t;

endpackage

/* rtl/gdc_lane.sv */
module gdc_lane #(
    parameter int AVG_DIVISOR = gdc_pkg::AVG_DIVISOR_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  logic [gdc_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [gdc_pkg::THR_REG_BITS-1:0] thr,
    output logic [gdc_pkg::SAMPLE_BITS-1:0] avg,
    output gdc_pkg::cmp_t                   cmp
);

    localparam int SB    = gdc_pkg::SAMPLE_BITS;
    localparam int TB    = gdc_pkg::THR_BITS;
    // reciprocal with enough fraction bits to be exact for any |diff| below 2**SB
    localparam int SHIFT = SB + 8;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'((2**SHIFT + AVG_DIVISOR - 1) / AVG_DIVISOR);

    logic [SB-1:0]       avg_reg;
    logic [SB-1:0]       avg_next;
    logic signed [SB:0]  diff;
    logic                diff_neg;
    logic [SB-1:0]       diff_mag;
    logic [SB+SHIFT-1:0] prod;
    logic [SB-1:0]       quot;

    logic signed [TB-1:0] avg_s;
    logic signed [TB-1:0] thr_lo;
    logic signed [TB-1:0] thr_mid_lo;
    logic signed [TB-1:0] thr_mid_hi;
    logic signed [TB-1:0] thr_hi;

    // avg += (sample - avg) / AVG_DIVISOR, quotient rounded toward zero
    always_comb
    begin
        diff     = $signed({1'b0, sample}) - $signed({1'b0, avg_reg});
        diff_neg = diff[SB];
        diff_mag = diff_neg ? SB'(-diff) : diff[SB-1:0];
        prod     = {{SHIFT{1'b0}}, diff_mag} * {{SB{1'b0}}, RECIP};
        quot     = prod[SB+SHIFT-1:SHIFT];
        avg_next = diff_neg ? (avg_reg - quot) : (avg_reg + quot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
        end
        else if (load)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

    always_comb
    begin
        avg_s      = $signed({{(TB-SB){1'b0}}, avg_reg});
        thr_lo     = $signed(thr[TB-1:0]);
        thr_mid_lo = $signed(thr[2*TB-1:TB]);
        thr_mid_hi = $signed(thr[3*TB-1:2*TB]);
        thr_hi     = $signed(thr[4*TB-1:3*TB]);

        cmp.ge_lo     = avg_s >= thr_lo;
        cmp.le_lo     = avg_s <= thr_lo;
        cmp.ge_mid_lo = avg_s >= thr_mid_lo;
        cmp.le_mid_lo = avg_s <= thr_mid_lo;
        cmp.ge_mid_hi = avg_s >= thr_mid_hi;
        cmp.le_mid_hi = avg_s <= thr_mid_hi;
        cmp.ge_hi     = avg_s >= thr_hi;
        cmp.le_hi     = avg_s <= thr_hi;
    end

`ifndef NO_ASSERTIONS
    // the new average lies between the old average and the sample
    a_avg_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (($past(sample) >= $past(avg_reg))
                  ? (avg_reg >= $past(avg_reg) && avg_reg <= $past(sample))
                  : (avg_reg <= $past(avg_reg) && avg_reg >= $past(sample))))
        else $error("lane average left the range between old average and sample");
`endif

endmodule

/* rtl/gdc_merge.sv */
module gdc_merge (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gdc_pkg::stage_ctl_t             ctl,
    input  gdc_pkg::cmp_t                   cmp_r,
    input  gdc_pkg::cmp_t                   cmp_l,
    input  gdc_pkg::cmp_t                   cmp_i,
    input  logic [gdc_pkg::SAMPLE_BITS-1:0] avg_r,
    input  logic [gdc_pkg::SAMPLE_BITS-1:0] avg_l,
    input  logic [gdc_pkg::SAMPLE_BITS-1:0] avg_i,
    output logic                            result_valid,
    output gdc_pkg::out_word_t              result
);

    typedef enum logic [gdc_pkg::DIR_BITS-1:0] {
        CENTER     = 3'd0,
        UP         = 3'd1,
        RIGHT      = 3'd2,
        DOWN       = 3'd3,
        LEFT       = 3'd4,
        DOWN_RIGHT = 3'd5,
        UP_LEFT    = 3'd6
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               result_valid_reg;
    gdc_pkg::out_word_t result_reg;
    logic               load;

    assign load = ctl.advance && ctl.s1_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CENTER:
            begin
                priority if (cmp_l.ge_hi && cmp_i.le_lo && cmp_r.le_lo)
                    state_next = RIGHT;
                else if (cmp_l.le_lo && cmp_i.ge_hi && cmp_r.ge_hi)
                    state_next = LEFT;
                else if (cmp_l.ge_mid_hi && cmp_l.le_hi && cmp_i.ge_mid_lo
                         && cmp_i.le_mid_hi && cmp_r.ge_hi)
                    state_next = UP;
                else if (cmp_l.ge_mid_hi && cmp_l.le_hi && cmp_i.ge_lo
                         && cmp_i.le_mid_lo && cmp_r.ge_hi)
                    state_next = DOWN;
                else if (cmp_l.ge_hi && cmp_i.ge_mid_lo && cmp_i.le_mid_hi && cmp_r.ge_hi)
                    state_next = UP_LEFT;
                else if (cmp_l.ge_hi && cmp_i.le_lo && cmp_r.ge_hi)
                    state_next = DOWN_RIGHT;
                else
                    state_next = CENTER;
            end
            RIGHT:
            begin
                if (cmp_l.le_mid_hi && cmp_i.ge_mid_lo && cmp_r.ge_mid_lo)
                    state_next = CENTER;
            end
            LEFT:
            begin
                if (cmp_l.ge_mid_lo && cmp_i.le_mid_hi && cmp_r.le_mid_hi)
                    state_next = CENTER;
            end
            UP:
            begin
                if (cmp_l.le_mid_hi && cmp_r.le_hi)
                    state_next = CENTER;
            end
            DOWN:
            begin
                if (cmp_l.le_mid_hi && cmp_i.ge_mid_lo && cmp_r.le_hi)
                    state_next = CENTER;
            end
            UP_LEFT:
            begin
                if (cmp_l.le_mid_hi && cmp_r.le_mid_hi)
                    state_next = CENTER;
            end
            DOWN_RIGHT:
            begin
                if (cmp_l.le_mid_hi && cmp_i.ge_mid_lo && cmp_r.le_mid_hi)
                    state_next = CENTER;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= CENTER;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else if (ctl.advance)
        begin
            result_valid_reg <= ctl.s1_valid;
            if (ctl.s1_valid)
            begin
                state_reg                    <= state_next;
                result_reg.gaze_direction    <= state_next;
                result_reg.direction_changed <= (state_next != state_reg);
                result_reg.avg_outer_right   <= avg_r;
                result_reg.avg_outer_left    <= avg_l;
                result_reg.avg_inner_left    <= avg_i;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result_reg.direction_changed
                 == (result_reg.gaze_direction != $past(state_reg)))
        else $error("changed flag does not match the direction move");

    a_dir_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg.gaze_direction == state_reg)
        else $error("shown direction differs from direction state");
`endif

endmodule

/* rtl/ir_gaze_direction_classifier.sv */
// pipeline: lane average registers (stage 1), then merge output register
// throughput: one sample word per cycle while the output is not stalled; the
//   average feedback closes in stage 1 and the direction machine in stage 2
// reset: rst_n is asynchronous, active low; it clears the averages to zero,
//   the direction to center, all thresholds to zero and empties the pipeline
module ir_gaze_direction_classifier #(
    parameter int AVG_DIVISOR = gdc_pkg::AVG_DIVISOR_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  gdc_pkg::in_word_t                sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output gdc_pkg::out_word_t               result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gdc_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [gdc_pkg::THR_REG_BITS-1:0] pwdata,
    output logic [gdc_pkg::THR_REG_BITS-1:0] prdata,
    output logic                             pready
);

    localparam logic [1:0] REG_OUTER_RIGHT = 2'd0;
    localparam logic [1:0] REG_OUTER_LEFT  = 2'd1;
    localparam logic [1:0] REG_INNER_LEFT  = 2'd2;

    logic [gdc_pkg::THR_REG_BITS-1:0] thr_r_reg;
    logic [gdc_pkg::THR_REG_BITS-1:0] thr_l_reg;
    logic [gdc_pkg::THR_REG_BITS-1:0] thr_i_reg;
    logic [1:0]                       reg_idx;
    logic                             cfg_write;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                load;
    logic                advance;
    gdc_pkg::stage_ctl_t ctl;

    logic [gdc_pkg::SAMPLE_BITS-1:0] avg_r;
    logic [gdc_pkg::SAMPLE_BITS-1:0] avg_l;
    logic [gdc_pkg::SAMPLE_BITS-1:0] avg_i;
    gdc_pkg::cmp_t                   cmp_r;
    gdc_pkg::cmp_t                   cmp_l;
    gdc_pkg::cmp_t                   cmp_i;

    // configuration registers at 8-byte spacing
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:3];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_r_reg <= '0;
            thr_l_reg <= '0;
            thr_i_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_OUTER_RIGHT: thr_r_reg <= pwdata;
                REG_OUTER_LEFT:  thr_l_reg <= pwdata;
                REG_INNER_LEFT:  thr_i_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_OUTER_RIGHT: prdata = thr_r_reg;
            REG_OUTER_LEFT:  prdata = thr_l_reg;
            REG_INNER_LEFT:  prdata = thr_i_reg;
            default:         prdata = '0;
        endcase
    end

    // stage 1 is the lane averages, stage 2 the output register in the merge
    assign advance      = !result_valid || result_ready;
    assign sample_ready = !s1_valid_reg || advance;
    assign load         = sample_valid && sample_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign ctl.advance  = advance;
    assign ctl.s1_valid = s1_valid_reg;

    gdc_lane #(
        .AVG_DIVISOR(AVG_DIVISOR)
    ) u_lane_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .sample (sample.sample_outer_right),
        .thr    (thr_r_reg),
        .avg    (avg_r),
        .cmp    (cmp_r)
    );

    gdc_lane #(
        .AVG_DIVISOR(AVG_DIVISOR)
    ) u_lane_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .sample (sample.sample_outer_left),
        .thr    (thr_l_reg),
        .avg    (avg_l),
        .cmp    (cmp_l)
    );

    gdc_lane #(
        .AVG_DIVISOR(AVG_DIVISOR)
    ) u_lane_i (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .sample (sample.sample_inner_left),
        .thr    (thr_i_reg),
        .avg    (avg_i),
        .cmp    (cmp_i)
    );

    gdc_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmp_r        (cmp_r),
        .cmp_l        (cmp_l),
        .cmp_i        (cmp_i),
        .avg_r        (avg_r),
        .avg_l        (avg_l),
        .avg_i        (avg_i),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    a_result_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s1_valid_reg))
        else $error("result word appeared without a word in the lane stage");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> s1_valid_reg && result_valid && !result_ready)
        else $error("sample side stalled while the pipeline had room");
`endif

endmodule
